@@ hw/rtl/hmb_pkg.sv @@
// ----------------------------------------------------------------------------
// hmb_pkg: shared types and constants for the wrapped heightmap blur
// Control word layout, tap offset codes, register map and reset values.
// ----------------------------------------------------------------------------
package hmb_pkg;

  // Neighbor offset applied to a row or column coordinate
  typedef enum logic [1:0] {
    OFF_ZERO  = 2'd0,
    OFF_MINUS = 2'd1,
    OFF_PLUS  = 2'd2
  } off_t;

  // One microcode word; drives the datapath during its step
  typedef struct packed {
    logic rd;       // read store at neighbor address
    logic wr;       // write latched pixel at center address
    logic acc_clr;  // clear accumulator
    logic mul;      // product <= read data * tap
    logic acc;      // accumulator += product
    logic scale;    // scaled <= accumulator * gain
    logic emit;     // load result registers, pulse done
    logic jmp_wr;   // jump to write routine if op is a store
    logic fin;      // last step, return to idle
    off_t roff;     // row offset of this read
    off_t coff;     // column offset of this read
  } uword_t;

  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] UPC_QUERY = 4'd0;
  localparam logic [UPC_W-1:0] UPC_WRITE = 4'd13;

  // Operations
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Arithmetic widths
  localparam int COEF_W  = 16;
  localparam int PROD_W  = 25;   // 8-bit unsigned sample (9 bits signed) x 16-bit tap
  localparam int ACC_W   = 30;   // nine products
  localparam int SCALE_W = 16;
  localparam int SPROD_W = ACC_W + SCALE_W;
  localparam int FRAC_W  = 14;
  localparam int LG_W    = 4;
  localparam logic [LG_W-1:0] MIN_LOG2 = 4'd4;

  // Register map (index = paddr[5:3])
  localparam logic [2:0] REG_MAP_LOG2  = 3'd0;
  localparam logic [2:0] REG_K_TOP     = 3'd1;
  localparam logic [2:0] REG_K_MID     = 3'd2;
  localparam logic [2:0] REG_K_BOTTOM  = 3'd3;
  localparam logic [2:0] REG_VSCALE    = 3'd4;

  localparam logic [3:0]  RST_MAP_LOG2 = 4'd8;
  localparam logic [47:0] RST_K_EDGE   = 48'h01EC_07AE_01EC;
  localparam logic [47:0] RST_K_MID    = 48'h07AE_199A_07AE;
  localparam logic [15:0] RST_VSCALE   = 16'h0100;

endpackage

@@ hw/rtl/wrapped_heightmap_blur_top.sv @@
// ----------------------------------------------------------------------------
// wrapped_heightmap_blur_top: toroidal 3x3 heightmap filter
// Heightmap store with a microcoded 3x3 wrapped convolution and gain.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transfer happens when start is high and busy is low.
//   op=0 stores pixel at (col,row); op=1 queries the filtered height there.
//   Coordinates are masked to the side 2^map_log2 (clamped to 4..MAX).
//   Results: out_col, out_row, height valid for one cycle while done is high.
//   The receiver cannot stall; each result must be taken when it appears.
// Timing:
//   A query holds busy through nine reads on the single store port, the
//   drain of the multiply-accumulate, one gain multiply and one output load.
//   done rises in the cycle busy drops, so the next command may be taken
//   in that same cycle. A store holds busy for its first step and its write step.
// Reset:
//   Registers return to their defaults (side 256, smoothing kernel, unit
//   gain). The store is not cleared; only written entries may be queried.
// Configuration: APB, 64-bit data, register i at byte address 8*i.
// ----------------------------------------------------------------------------
module wrapped_heightmap_blur_top #(
  parameter int MAX_SIDE_LOG2 = 8
) (
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [7:0]         col,
  input  logic [7:0]         row,
  input  logic [7:0]         pixel,
  // result channel
  output logic               done,
  output logic [7:0]         out_col,
  output logic [7:0]         out_row,
  output logic signed [31:0] height,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  logic [3:0]                      map_log2;
  logic [2:0][47:0]                krows;
  logic signed [hmb_pkg::SCALE_W-1:0] vscale;
  logic [2:0]                      reg_idx;
  logic                            cfg_wr;
  logic [hmb_pkg::LG_W-1:0]        lg;
  logic                            accept;
  logic                            op_wr;
  hmb_pkg::uword_t                 uw;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel & penable & pwrite & pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_log2 <= hmb_pkg::RST_MAP_LOG2;
      krows[0] <= hmb_pkg::RST_K_EDGE;
      krows[1] <= hmb_pkg::RST_K_MID;
      krows[2] <= hmb_pkg::RST_K_EDGE;
      vscale   <= hmb_pkg::RST_VSCALE;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        hmb_pkg::REG_MAP_LOG2: map_log2 <= pwdata[3:0];
        hmb_pkg::REG_K_TOP:    krows[0] <= pwdata[47:0];
        hmb_pkg::REG_K_MID:    krows[1] <= pwdata[47:0];
        hmb_pkg::REG_K_BOTTOM: krows[2] <= pwdata[47:0];
        hmb_pkg::REG_VSCALE:   vscale   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      hmb_pkg::REG_MAP_LOG2: prdata = {60'd0, map_log2};
      hmb_pkg::REG_K_TOP:    prdata = {16'd0, krows[0]};
      hmb_pkg::REG_K_MID:    prdata = {16'd0, krows[1]};
      hmb_pkg::REG_K_BOTTOM: prdata = {16'd0, krows[2]};
      hmb_pkg::REG_VSCALE:   prdata = {48'd0, vscale};
      default:               prdata = 64'd0;
    endcase
  end

  // Effective side log2, clamped to the supported range
  always_comb begin
    if (map_log2 < hmb_pkg::MIN_LOG2) begin
      lg = hmb_pkg::MIN_LOG2;
    end else if (map_log2 > hmb_pkg::LG_W'(MAX_SIDE_LOG2)) begin
      lg = hmb_pkg::LG_W'(MAX_SIDE_LOG2);
    end else begin
      lg = map_log2;
    end
  end

  hmb_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op_wr  (op_wr),
    .busy   (busy),
    .accept (accept),
    .uw     (uw)
  );

  hmb_dpath #(
    .MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .op      (op),
    .col     (col),
    .row     (row),
    .pixel   (pixel),
    .lg      (lg),
    .krows   (krows),
    .vscale  (vscale),
    .uw      (uw),
    .op_wr   (op_wr),
    .out_col (out_col),
    .out_row (out_row),
    .height  (height),
    .done    (done)
  );

endmodule

@@ hw/rtl/hmb_ram.sv @@
// ----------------------------------------------------------------------------
// hmb_ram: generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module hmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ hw/rtl/hmb_useq.sv @@
// ----------------------------------------------------------------------------
// hmb_useq: microcode sequencer
// Step counter over a control ROM, with a conditional jump on the op code.
// ----------------------------------------------------------------------------
module hmb_useq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            op_wr,
  output logic            busy,
  output logic            accept,
  output hmb_pkg::uword_t uw
);

  logic [hmb_pkg::UPC_W-1:0] upc;
  hmb_pkg::uword_t           rom_word;

  // Control ROM
  function automatic hmb_pkg::uword_t urom(input logic [hmb_pkg::UPC_W-1:0] a);
    hmb_pkg::uword_t w;
    w = '0;
    w.roff = hmb_pkg::OFF_ZERO;
    w.coff = hmb_pkg::OFF_ZERO;
    unique case (a)
      4'd0: begin
        w.rd = 1'b1; w.acc_clr = 1'b1; w.jmp_wr = 1'b1;
        w.roff = hmb_pkg::OFF_MINUS; w.coff = hmb_pkg::OFF_MINUS;
      end
      4'd1: begin
        w.rd = 1'b1; w.mul = 1'b1;
        w.roff = hmb_pkg::OFF_MINUS; w.coff = hmb_pkg::OFF_ZERO;
      end
      4'd2: begin
        w.rd = 1'b1; w.mul = 1'b1; w.acc = 1'b1;
        w.roff = hmb_pkg::OFF_MINUS; w.coff = hmb_pkg::OFF_PLUS;
      end
      4'd3: begin
        w.rd = 1'b1; w.mul = 1'b1; w.acc = 1'b1;
        w.roff = hmb_pkg::OFF_ZERO; w.coff = hmb_pkg::OFF_MINUS;
      end
      4'd4: begin
        w.rd = 1'b1; w.mul = 1'b1; w.acc = 1'b1;
        w.roff = hmb_pkg::OFF_ZERO; w.coff = hmb_pkg::OFF_ZERO;
      end
      4'd5: begin
        w.rd = 1'b1; w.mul = 1'b1; w.acc = 1'b1;
        w.roff = hmb_pkg::OFF_ZERO; w.coff = hmb_pkg::OFF_PLUS;
      end
      4'd6: begin
        w.rd = 1'b1; w.mul = 1'b1; w.acc = 1'b1;
        w.roff = hmb_pkg::OFF_PLUS; w.coff = hmb_pkg::OFF_MINUS;
      end
      4'd7: begin
        w.rd = 1'b1; w.mul = 1'b1; w.acc = 1'b1;
        w.roff = hmb_pkg::OFF_PLUS; w.coff = hmb_pkg::OFF_ZERO;
      end
      4'd8: begin
        w.rd = 1'b1; w.mul = 1'b1; w.acc = 1'b1;
        w.roff = hmb_pkg::OFF_PLUS; w.coff = hmb_pkg::OFF_PLUS;
      end
      4'd9:  begin w.mul = 1'b1; w.acc = 1'b1; end
      4'd10: begin w.acc = 1'b1; end
      4'd11: begin w.scale = 1'b1; end
      4'd12: begin w.emit = 1'b1; w.fin = 1'b1; end
      4'd13: begin w.wr = 1'b1; w.fin = 1'b1; end
      default: begin w.fin = 1'b1; end
    endcase
    return w;
  endfunction

  assign rom_word = urom(upc);
  assign uw       = busy ? rom_word : '0;
  assign accept   = start & ~busy;

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      upc  <= hmb_pkg::UPC_QUERY;
    end else if (accept) begin
      busy <= 1'b1;
      upc  <= hmb_pkg::UPC_QUERY;
    end else if (busy) begin
      if (rom_word.fin) begin
        busy <= 1'b0;
      end else if (rom_word.jmp_wr && op_wr) begin
        upc <= hmb_pkg::UPC_WRITE;
      end else begin
        upc <= upc + 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/hmb_dpath.sv @@
// ----------------------------------------------------------------------------
// hmb_dpath: heightmap datapath
// Input latch, wrapped address generation, height store, MAC and gain stage.
// ----------------------------------------------------------------------------
module hmb_dpath #(
  parameter int MAX_SIDE_LOG2 = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          op,
  input  logic [7:0]                    col,
  input  logic [7:0]                    row,
  input  logic [7:0]                    pixel,
  input  logic [hmb_pkg::LG_W-1:0]      lg,
  input  logic [2:0][47:0]              krows,
  input  logic signed [hmb_pkg::SCALE_W-1:0] vscale,
  input  hmb_pkg::uword_t               uw,
  output logic                          op_wr,
  output logic [7:0]                    out_col,
  output logic [7:0]                    out_row,
  output logic signed [31:0]            height,
  output logic                          done
);

  localparam int CW = MAX_SIDE_LOG2;
  localparam int AW = 2 * CW;

  logic            op_q;
  logic [CW-1:0]   col_q, row_q;
  logic [7:0]      pixel_q;
  logic [CW-1:0]   mask, col_in, row_in, r_n, c_n;
  logic [CW+7:0]   col_ext, row_ext;
  logic [AW-1:0]   addr;
  logic [7:0]      rdata;
  logic [7:0]      ocol_ext, orow_ext;
  logic [CW+7:0]   ocol_tmp, orow_tmp;
  hmb_pkg::off_t   roff_q, coff_q;
  logic [1:0]      ky, kx;
  logic signed [hmb_pkg::COEF_W-1:0]  coef;
  logic signed [hmb_pkg::PROD_W-1:0]  prod, prod_next;
  logic signed [hmb_pkg::ACC_W-1:0]   acc;
  logic signed [hmb_pkg::SPROD_W-1:0] sprod, sprod_next;

  function automatic logic [CW-1:0] step(input logic [CW-1:0] v, input hmb_pkg::off_t o);
    logic [CW-1:0] r;
    unique case (o)
      hmb_pkg::OFF_MINUS: r = v - 1'b1;
      hmb_pkg::OFF_PLUS:  r = v + 1'b1;
      default:            r = v;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] off_idx(input hmb_pkg::off_t o);
    logic [1:0] r;
    unique case (o)
      hmb_pkg::OFF_MINUS: r = 2'd0;
      hmb_pkg::OFF_PLUS:  r = 2'd2;
      default:            r = 2'd1;
    endcase
    return r;
  endfunction

  // Coordinate masking to the current side
  assign mask    = ~({CW{1'b1}} << lg);
  assign col_ext = {{CW{1'b0}}, col};
  assign row_ext = {{CW{1'b0}}, row};
  assign col_in  = col_ext[CW-1:0] & mask;
  assign row_in  = row_ext[CW-1:0] & mask;

  // Input latch
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op;
      col_q   <= col_in;
      row_q   <= row_in;
      pixel_q <= pixel;
    end
  end
  assign op_wr = (op_q == hmb_pkg::OP_WRITE);

  // Wrapped neighbor address (center for a store)
  assign r_n  = step(row_q, uw.roff) & mask;
  assign c_n  = step(col_q, uw.coff) & mask;
  assign addr = (AW'(r_n) << lg) | AW'(c_n);

  hmb_ram #(
    .WIDTH (8),
    .DEPTH (1 << AW)
  ) u_store (
    .clk   (clk),
    .en    (uw.rd | uw.wr),
    .we    (uw.wr),
    .addr  (addr),
    .wdata (pixel_q),
    .rdata (rdata)
  );

  // Tap select is registered so that it lines up with the registered read data
  always_ff @(posedge clk) begin
    roff_q <= uw.roff;
    coff_q <= uw.coff;
  end
  assign ky   = off_idx(roff_q);
  assign kx   = off_idx(coff_q);
  assign coef = krows[ky][16*kx +: 16];

  // Multiply-accumulate and gain
  assign prod_next  = $signed({1'b0, rdata}) * coef;
  assign sprod_next = acc * vscale;

  always_ff @(posedge clk) begin
    if (uw.mul) begin
      prod <= prod_next;
    end
    if (uw.acc_clr) begin
      acc <= '0;
    end else if (uw.acc) begin
      acc <= acc + hmb_pkg::ACC_W'(prod);
    end
    if (uw.scale) begin
      sprod <= sprod_next;
    end
  end

  // Result registers; floor shift is a plain bit select
  assign ocol_tmp = {8'd0, col_q};
  assign orow_tmp = {8'd0, row_q};
  assign ocol_ext = ocol_tmp[7:0];
  assign orow_ext = orow_tmp[7:0];

  always_ff @(posedge clk) begin
    if (uw.emit) begin
      out_col <= ocol_ext;
      out_row <= orow_ext;
      height  <= sprod[hmb_pkg::FRAC_W +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= uw.emit;
    end
  end

endmodule
